// File: sv/vps_pkg.sv
// Shared types, constants and helpers for the Verlet particle solver.
// Used by vps_store, vps_mul, vps_dsq and verlet_particle_solver.
package vps_pkg;

	localparam int PARTICLE_COUNT = 256;
	localparam int IDX_W          = $clog2(PARTICLE_COUNT);
	localparam int FRACTION_BITS  = 16;
	localparam int DIR_BITS       = 24;

	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 33;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 40;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 26;
	localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

	localparam logic [16:0] DAMP_ONE = 17'd65536;

	localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(64'sd2147483648);

	typedef enum logic [2:0] {
		ACT_LOAD   = 3'd0,
		ACT_SET    = 3'd1,
		ACT_INTEG  = 3'd2,
		ACT_CONSTR = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DEGEN = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_GX   = 3'd0,
		CFG_GY   = 3'd1,
		CFG_GZ   = 3'd2,
		CFG_DAMP = 3'd3
	} cfg_reg_t;

	typedef logic [2:0][31:0] vec3_t;

	typedef struct packed {
		logic cur;
		logic prev;
		logic w;
	} store_we_t;

	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [63:0] num;
		logic [33:0] den;
	} dsq_req_t;

	typedef struct packed {
		logic                    clamped;
		logic signed [31:0]      value;
	} sat_t;

	// Round to nearest, ties toward plus infinity, then drop k bits.
	function automatic logic signed [MUL_P_W-1:0] round_shift(
		input logic signed [MUL_P_W-1:0] p,
		input int unsigned               k
	);
		logic signed [MUL_P_W-1:0] half;
		half = MUL_P_W'(1) <<< (k - 1);
		return (p + half) >>> k;
	endfunction

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		if (v > POS_MAX) begin
			r.clamped = 1'b1;
			r.value   = 32'sh7fffffff;
		end else if (v < POS_MIN) begin
			r.clamped = 1'b1;
			r.value   = 32'sh80000000;
		end else begin
			r.clamped = 1'b0;
			r.value   = 32'(v);
		end
		return r;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [32:0] d);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

endpackage

// File: sv/vps_store.sv
// Particle table: current position, previous position and inverse mass.
// One address per cycle, separate write enables, registered read. Uses vps_pkg.
module vps_store (
	input  logic                      clk,
	input  logic [vps_pkg::IDX_W-1:0] addr,
	input  vps_pkg::store_we_t        we,
	input  vps_pkg::vec3_t            wr_cur,
	input  vps_pkg::vec3_t            wr_prev,
	input  logic [23:0]               wr_w,
	output vps_pkg::vec3_t            rd_cur,
	output vps_pkg::vec3_t            rd_prev,
	output logic [23:0]               rd_w
);
	import vps_pkg::*;

	vec3_t       cur_mem  [PARTICLE_COUNT];
	vec3_t       prev_mem [PARTICLE_COUNT];
	logic [23:0] w_mem    [PARTICLE_COUNT];

	always_ff @(posedge clk) begin
		if (we.cur)
			cur_mem[addr] <= wr_cur;
		if (we.prev)
			prev_mem[addr] <= wr_prev;
		if (we.w)
			w_mem[addr] <= wr_w;
		rd_cur  <= cur_mem[addr];
		rd_prev <= prev_mem[addr];
		rd_w    <= w_mem[addr];
	end

endmodule

// File: sv/vps_mul.sv
// Shared signed multiplier with a registered product.
// Widths come from vps_pkg.
module vps_mul (
	input  logic                              clk,
	input  logic signed [vps_pkg::MUL_A_W-1:0] a,
	input  logic signed [vps_pkg::MUL_B_W-1:0] b,
	output logic signed [vps_pkg::MUL_P_W-1:0] p
);
	import vps_pkg::*;

	always_ff @(posedge clk) begin
		p <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

// File: sv/vps_dsq.sv
// Iterative divide / square root unit, one compare-subtract per cycle.
// Square root: two radicand bits a step; divide: one quotient bit a step. Uses vps_pkg.
module vps_dsq (
	input  logic              clk,
	input  logic              arst_n,
	input  vps_pkg::dsq_req_t req,
	output logic              done,
	output logic [32:0]       res
);
	import vps_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sqrt_q;
	logic [35:0]      rem_q;
	logic [32:0]      res_q;
	logic [63:0]      src_q;
	logic [33:0]      den_q;

	logic [35:0] r2;
	logic [35:0] trial;
	logic [36:0] diff;
	logic        ge;

	always_comb begin
		r2    = sqrt_q ? {rem_q[33:0], src_q[63:62]} : {rem_q[34:0], src_q[63]};
		trial = sqrt_q ? {1'b0, res_q, 2'b01} : {2'b00, den_q};
		diff  = {1'b0, r2} - {1'b0, trial};
		ge    = ~diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.is_sqrt;
			den_q  <= req.den;
			res_q  <= '0;
			// a divide starts with the high bits already in the remainder
			rem_q  <= req.is_sqrt ? '0 : 36'(req.num >> DIV_STEPS);
			src_q  <= req.is_sqrt ? req.num : (req.num << (64 - DIV_STEPS));
		end else if (busy_q) begin
			rem_q <= ge ? diff[35:0] : r2;
			res_q <= {res_q[31:0], ge};
			src_q <= sqrt_q ? (src_q << 2) : (src_q << 1);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: sv/verlet_particle_solver.sv
// Verlet particle solver top level: sequencer, config registers, output register.
// Depends on vps_pkg, vps_store, vps_mul and vps_dsq.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   action, index_a, index_b, rest_length,
//                                              new_x/y/z, new_inverse_mass,
//                                              also_set_previous, time_step
//   out       output     out_valid / out_ready out_x, out_y, out_z, status
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. Integrate runs one multiply for the squared time step, then
// two multiplies per axis through the shared multiplier; a length constraint uses
// the 32-step square root and five 26-step divides in the shared divide/root unit.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled out beat holds the sequencer
// in its last state. Reset clears control and loads the register defaults; the
// particle table is not cleared. cfg_ready is always high.
module verlet_particle_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  index_a,
	input  logic [7:0]  index_b,
	input  logic [30:0] rest_length,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [31:0] new_z,
	input  logic [23:0] new_inverse_mass,
	input  logic        also_set_previous,
	input  logic [15:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import vps_pkg::*;

	typedef enum logic [29:0] {
		S_IDLE = 30'd1 << 0,
		S_WRA  = 30'd1 << 1,
		S_WRB  = 30'd1 << 2,
		S_RDA  = 30'd1 << 3,
		S_RDB  = 30'd1 << 4,
		S_CAPB = 30'd1 << 5,
		S_DT   = 30'd1 << 6,
		S_DT2  = 30'd1 << 7,
		S_VMUL = 30'd1 << 8,
		S_GMUL = 30'd1 << 9,
		S_ISUM = 30'd1 << 10,
		S_DLT  = 30'd1 << 11,
		S_SQ   = 30'd1 << 12,
		S_SQAC = 30'd1 << 13,
		S_SQRT = 30'd1 << 14,
		S_SQW  = 30'd1 << 15,
		S_CHK  = 30'd1 << 16,
		S_SHA  = 30'd1 << 17,
		S_SHAW = 30'd1 << 18,
		S_SHB  = 30'd1 << 19,
		S_SHBW = 30'd1 << 20,
		S_STA  = 30'd1 << 21,
		S_STB  = 30'd1 << 22,
		S_STC  = 30'd1 << 23,
		S_DIR  = 30'd1 << 24,
		S_DIRW = 30'd1 << 25,
		S_QA   = 30'd1 << 26,
		S_QB   = 30'd1 << 27,
		S_QBC  = 30'd1 << 28,
		S_DONE = 30'd1 << 29
	} state_t;

	state_t state_q;

	// config
	logic [2:0][31:0] grav_q;
	logic [16:0]      damp_q;

	// captured item
	logic [2:0]       act_q;
	logic [IDX_W-1:0] ia_q;
	logic [IDX_W-1:0] ib_q;
	logic [30:0]      len_q;
	logic [23:0]      nw_q;
	logic             setp_q;
	logic [15:0]      dt_q;

	// working registers
	vec3_t            ca_q, pa_q, cb_q, na_q, nb_q;
	logic [23:0]      wa_q, wb_q;
	logic [2:0][32:0] d_q;
	logic             sh_q;
	logic [63:0]      sum_q;
	logic [33:0]      dist_q;
	logic [16:0]      dt2_q;
	logic signed [33:0] v_q;
	logic signed [35:0] step_q, sa_q, sb_q;
	logic [16:0]      sha_q, shb_q;
	logic signed [32:0] q_q;
	logic             sat_q, deg_q;
	logic [1:0]       ax_q;

	// output register
	logic             out_valid_q;
	vec3_t            res_q;
	logic [1:0]       st_q;

	// submodule wiring
	logic [IDX_W-1:0] st_addr;
	store_we_t        st_we;
	vec3_t            wr_cur, wr_prev;
	vec3_t            rd_cur, rd_prev;
	logic [23:0]      rd_w;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	dsq_req_t         dsq_req;
	logic             dsq_done;
	logic [32:0]      dsq_res;

	// datapath helpers
	logic               is_load, is_set, is_integ, is_constr;
	logic signed [31:0] ca_ax, pa_ax, cb_ax, g_ax;
	logic signed [32:0] d_ax;
	logic [32:0]        m_ax;
	logic [31:0]        msq;
	logic signed [32:0] dvel;
	logic [24:0]        tot;
	logic signed [MUL_P_W-1:0] rnd16, rnd24;
	logic [2:0][32:0]   dn;
	logic [2:0][32:0]   mn;
	logic               big;
	sat_t               sat_i, sat_a, sat_b;
	logic               accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		is_load   = (act_q == ACT_LOAD);
		is_set    = (act_q == ACT_SET);
		is_integ  = (act_q == ACT_INTEG);
		is_constr = (act_q == ACT_CONSTR);
		ca_ax     = ca_q[ax_q];
		pa_ax     = pa_q[ax_q];
		cb_ax     = cb_q[ax_q];
		g_ax      = grav_q[ax_q];
		d_ax      = d_q[ax_q];
		m_ax      = mag33(d_ax);
		msq       = sh_q ? 32'(m_ax >> 2) : 32'(m_ax);
		dvel      = 33'(ca_ax) - 33'(pa_ax);
		tot       = 25'(wa_q) + 25'(wb_q);
		rnd16     = round_shift(mul_p, FRACTION_BITS);
		rnd24     = round_shift(mul_p, DIR_BITS);
		big       = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dn[i] = 33'($signed(cb_q[i])) - 33'($signed(ca_q[i]));
			mn[i] = mag33(dn[i]);
			big   = big | (|mn[i][32:31]);
		end
		sat_i = sat32(ACC_W'(ca_ax) + ACC_W'(v_q)
			+ ((wa_q == '0) ? ACC_W'(0) : ACC_W'(rnd16)));
		sat_a = sat32(ACC_W'(ca_ax) + ACC_W'(rnd24));
		sat_b = sat32(ACC_W'(cb_ax) - ACC_W'(rnd24));
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DT: begin
				mul_a = MUL_A_W'(dt_q);
				mul_b = MUL_B_W'(dt_q);
			end
			S_VMUL: begin
				mul_a = MUL_A_W'(dvel);
				mul_b = MUL_B_W'(damp_q);
			end
			S_GMUL: begin
				mul_a = MUL_A_W'(g_ax);
				mul_b = MUL_B_W'(dt2_q);
			end
			S_SQ: begin
				mul_a = MUL_A_W'(msq);
				mul_b = MUL_B_W'(msq);
			end
			S_STA: begin
				mul_a = step_q;
				mul_b = MUL_B_W'(sha_q);
			end
			S_STB: begin
				mul_a = step_q;
				mul_b = MUL_B_W'(shb_q);
			end
			S_QA: begin
				mul_a = sa_q;
				mul_b = q_q;
			end
			S_QB: begin
				mul_a = sb_q;
				mul_b = q_q;
			end
			default: begin
			end
		endcase
	end

	// divide / root requests
	always_comb begin
		dsq_req = '0;
		unique case (state_q)
			S_SQRT: begin
				dsq_req.start   = 1'b1;
				dsq_req.is_sqrt = 1'b1;
				dsq_req.num     = sum_q;
			end
			S_SHA: begin
				dsq_req.start = 1'b1;
				dsq_req.num   = 64'({wa_q, FRACTION_BITS'(0)}) + 64'(tot >> 1);
				dsq_req.den   = 34'(tot);
			end
			S_SHB: begin
				dsq_req.start = 1'b1;
				dsq_req.num   = 64'({wb_q, FRACTION_BITS'(0)}) + 64'(tot >> 1);
				dsq_req.den   = 34'(tot);
			end
			S_DIR: begin
				dsq_req.start = 1'b1;
				dsq_req.num   = 64'({m_ax, DIR_BITS'(0)}) + 64'(dist_q >> 1);
				dsq_req.den   = dist_q;
			end
			default: begin
			end
		endcase
	end

	// table port
	always_comb begin
		st_addr = ia_q;
		st_we   = '0;
		wr_cur  = na_q;
		wr_prev = is_integ ? ca_q : na_q;
		unique case (state_q)
			S_RDB: st_addr = ib_q;
			S_WRA: begin
				st_we.cur  = 1'b1;
				st_we.prev = is_load || (is_set && setp_q) || is_integ;
				st_we.w    = is_load;
			end
			S_WRB: begin
				st_addr   = ib_q;
				st_we.cur = 1'b1;
				wr_cur    = nb_q;
			end
			default: begin
			end
		endcase
	end

	vps_store u_store (
		.clk     (clk),
		.addr    (st_addr),
		.we      (st_we),
		.wr_cur  (wr_cur),
		.wr_prev (wr_prev),
		.wr_w    (nw_q),
		.rd_cur  (rd_cur),
		.rd_prev (rd_prev),
		.rd_w    (rd_w)
	);

	vps_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	vps_dsq u_dsq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dsq_req),
		.done   (dsq_done),
		.res    (dsq_res)
	);

	// sequencer and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ax_q        <= '0;
			out_valid_q <= 1'b0;
			grav_q[0]   <= 32'sd0;
			grav_q[1]   <= -32'sd642253;
			grav_q[2]   <= 32'sd0;
			damp_q      <= 17'd65470;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GX:   grav_q[0] <= cfg_data;
					CFG_GY:   grav_q[1] <= cfg_data;
					CFG_GZ:   grav_q[2] <= cfg_data;
					CFG_DAMP: damp_q <= (cfg_data[16:0] > DAMP_ONE) ? DAMP_ONE : cfg_data[16:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= (action == ACT_LOAD || action == ACT_SET) ? S_WRA : S_RDA;
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB: begin
					ax_q <= '0;
					if (is_integ)
						state_q <= S_DT;
					else if (is_constr)
						state_q <= S_CAPB;
					else
						state_q <= S_DONE;
				end
				S_CAPB: state_q <= S_DLT;
				S_DT:   state_q <= S_DT2;
				S_DT2:  state_q <= S_VMUL;
				S_VMUL: state_q <= S_GMUL;
				S_GMUL: state_q <= S_ISUM;
				S_ISUM: begin
					if (ax_q == 2'd2) begin
						state_q <= S_WRA;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_VMUL;
					end
				end
				S_DLT: begin
					ax_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ:   state_q <= S_SQAC;
				S_SQAC: begin
					if (ax_q == 2'd2) begin
						state_q <= S_SQRT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SQRT: state_q <= S_SQW;
				S_SQW:  if (dsq_done) state_q <= S_CHK;
				S_CHK:  state_q <= (dist_q == '0 || tot == '0) ? S_DONE : S_SHA;
				S_SHA:  state_q <= S_SHAW;
				S_SHAW: if (dsq_done) state_q <= S_SHB;
				S_SHB:  state_q <= S_SHBW;
				S_SHBW: if (dsq_done) state_q <= S_STA;
				S_STA:  state_q <= S_STB;
				S_STB:  state_q <= S_STC;
				S_STC: begin
					ax_q    <= '0;
					state_q <= S_DIR;
				end
				S_DIR:  state_q <= S_DIRW;
				S_DIRW: if (dsq_done) state_q <= S_QA;
				S_QA:   state_q <= S_QB;
				S_QB:   state_q <= S_QBC;
				S_QBC: begin
					if (ax_q == 2'd2) begin
						state_q <= S_WRA;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_DIR;
					end
				end
				S_WRA:  state_q <= is_constr ? S_WRB : S_DONE;
				S_WRB:  state_q <= S_DONE;
				S_DONE: begin
					// hold until the previous out beat is gone
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_q  <= action;
					ia_q   <= index_a[IDX_W-1:0];
					ib_q   <= index_b[IDX_W-1:0];
					len_q  <= rest_length;
					nw_q   <= new_inverse_mass;
					setp_q <= also_set_previous;
					dt_q   <= time_step;
					na_q   <= {new_z, new_y, new_x};
					sat_q  <= 1'b0;
					deg_q  <= 1'b0;
				end
			end
			S_RDB: begin
				ca_q <= rd_cur;
				pa_q <= rd_prev;
				wa_q <= rd_w;
				na_q <= rd_cur;
			end
			S_CAPB: begin
				cb_q <= rd_cur;
				wb_q <= rd_w;
			end
			S_DT2:  dt2_q <= 17'(rnd16);
			S_GMUL: v_q <= 34'(rnd16);
			S_ISUM: begin
				na_q[ax_q] <= sat_i.value;
				sat_q      <= sat_q | sat_i.clamped;
			end
			S_DLT: begin
				d_q   <= dn;
				sh_q  <= big;
				sum_q <= '0;
			end
			S_SQAC: sum_q <= sum_q + 64'(mul_p);
			S_SQW: begin
				if (dsq_done)
					dist_q <= sh_q ? {dsq_res[31:0], 2'b00} : {2'b00, dsq_res[31:0]};
			end
			S_CHK: begin
				step_q <= $signed({2'b00, dist_q}) - $signed({5'b0, len_q});
				if (dist_q == '0 || tot == '0)
					deg_q <= 1'b1;
			end
			S_SHAW: if (dsq_done) sha_q <= dsq_res[16:0];
			S_SHBW: if (dsq_done) shb_q <= dsq_res[16:0];
			S_STB:  sa_q <= 36'(rnd16);
			S_STC:  sb_q <= 36'(rnd16);
			S_DIRW: begin
				if (dsq_done)
					q_q <= d_ax[32] ? -$signed(dsq_res) : $signed(dsq_res);
			end
			S_QB: begin
				na_q[ax_q] <= sat_a.value;
				sat_q      <= sat_q | sat_a.clamped;
			end
			S_QBC: begin
				nb_q[ax_q] <= sat_b.value;
				sat_q      <= sat_q | sat_b.clamped;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					res_q <= na_q;
					st_q  <= sat_q ? ST_SAT : (deg_q ? ST_DEGEN : ST_OK);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign status    = st_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while an item is in progress");

	a_dsq_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dsq_done |-> (state_q == S_SQW || state_q == S_SHAW || state_q == S_SHBW
			|| state_q == S_DIRW))
		else $error("divide/root result arrived outside a wait state");

	a_wrb_constr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB) |-> (is_constr && !deg_q))
		else $error("second particle written outside a live constraint");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_DEGEN || status == ST_SAT))
		else $error("undefined status code on out");

endmodule
